>>> rtl/dpfa_pkg.sv
// dpfa_pkg: shared constants for the demand paging frame allocator.
// Depends on nothing; used by demand_paging_frame_allocator_top, dpfa_scoreboard and the testbench.
package dpfa_pkg;

    localparam int NUM_PROCS_DEF  = 8;
    localparam int PAGE_BYTES_DEF = 64;
    localparam int VIRT_BYTES_DEF = 1024;
    localparam int PHYS_BYTES_DEF = 4096;

    // Fixed field widths of the command and result words
    localparam int OP_W    = 2;
    localparam int PID_W   = 3;
    localparam int VADDR_W = 10;
    localparam int SIZE_W  = 11;
    localparam int DATA_W  = 8;
    localparam int STAT_W  = 3;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
    localparam logic [OP_W-1:0] OP_EXIT   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SLOT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_RESERVE = 3'd3;
    localparam logic [STAT_W-1:0] ST_IDLE       = 3'd4;
    localparam logic [STAT_W-1:0] ST_OOB        = 3'd5;
    localparam logic [STAT_W-1:0] ST_NO_FRAME   = 3'd6;

endpackage

>>> rtl/demand_paging_frame_allocator_top.sv
// demand_paging_frame_allocator_top: per-process demand paging with first-fit frames.
// Depends on dpfa_pkg and dpfa_ram (page table RAM and physical memory RAM).
//
//  channel  | handshake         | word
//  ---------+-------------------+-----------------------------------------
//  command  | start, busy       | op, proc_id, vaddr, size_bytes, wdata
//  result   | done (one cycle)  | status, new_proc_id, rdata
//
// Create, idle-slot and out-of-bounds commands answer in the cycle after accept
// with busy never raised. A byte access to a mapped page reads the page table RAM
// (S_PT_WAIT), then accesses physical RAM (S_ACC), plus S_RD_WAIT for a read.
// First touch adds a first-fit scan of used_reg, one frame per cycle, plus a zero
// fill of all PAGE_BYTES bytes of the frame through the single physical RAM port.
// Exit walks the slot's VPAGES page table entries through S_EX_RD and S_EX_USE.
// Reset clears all control state and valid bits at once; no clearing pass.
// The result receiver cannot stall; done pulses for exactly one cycle.
module demand_paging_frame_allocator_top #(
    parameter int NUM_PROCS  = dpfa_pkg::NUM_PROCS_DEF,
    parameter int PAGE_BYTES = dpfa_pkg::PAGE_BYTES_DEF,
    parameter int VIRT_BYTES = dpfa_pkg::VIRT_BYTES_DEF,
    parameter int PHYS_BYTES = dpfa_pkg::PHYS_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dpfa_pkg::OP_W-1:0]    op,
    input  logic [dpfa_pkg::PID_W-1:0]   proc_id,
    input  logic [dpfa_pkg::VADDR_W-1:0] vaddr,
    input  logic [dpfa_pkg::SIZE_W-1:0]  size_bytes,
    input  logic [dpfa_pkg::DATA_W-1:0]  wdata,
    output logic                         done,
    output logic [dpfa_pkg::STAT_W-1:0]  status,
    output logic [dpfa_pkg::PID_W-1:0]   new_proc_id,
    output logic [dpfa_pkg::DATA_W-1:0]  rdata
);

    localparam int VPAGES   = (VIRT_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int FRAMES   = PHYS_BYTES / PAGE_BYTES;
    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int SLOT_W   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int VPN_W    = (VPAGES > 1) ? $clog2(VPAGES) : 1;
    localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FC_W     = $clog2(FRAMES + 1);
    localparam int PT_DEPTH = NUM_PROCS * VPAGES;
    localparam int PT_AW    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int PH_DEPTH = (1 << FRAME_W) * PAGE_BYTES;
    localparam int PA_W     = FRAME_W + OFF_W;
    localparam int RES_W    = $clog2(FRAMES + 1);
    localparam int SUM_W    = $clog2(FRAMES + VPAGES + 1);
    localparam int NP_W     = $clog2(VPAGES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PT_WAIT,
        S_ACC,
        S_RD_WAIT,
        S_FSCAN,
        S_ZERO,
        S_EX_RD,
        S_EX_USE
    } state_t;

    state_t                      state_reg, state_next;
    logic [NUM_PROCS-1:0]        running_reg, running_next;
    logic [dpfa_pkg::SIZE_W-1:0] size_reg [NUM_PROCS];
    logic [dpfa_pkg::SIZE_W-1:0] size_next [NUM_PROCS];
    logic [PT_DEPTH-1:0]         present_reg, present_next;
    logic [FRAMES-1:0]           used_reg, used_next;
    logic [RES_W-1:0]            reserved_reg, reserved_next;

    logic [dpfa_pkg::OP_W-1:0]    op_reg, op_next;
    logic [SLOT_W-1:0]            pid_reg, pid_next;
    logic [OFF_W-1:0]             off_reg, off_next;
    logic [dpfa_pkg::DATA_W-1:0]  wdata_reg, wdata_next;
    logic [PT_AW-1:0]             idx_reg, idx_next;
    logic [FRAME_W-1:0]           frame_reg, frame_next;
    logic [FC_W-1:0]              fcnt_reg, fcnt_next;
    logic [OFF_W-1:0]             zcnt_reg, zcnt_next;
    logic [VPN_W-1:0]             vcnt_reg, vcnt_next;

    logic                         done_reg, done_next;
    logic [dpfa_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [dpfa_pkg::PID_W-1:0]   newpid_reg, newpid_next;
    logic [dpfa_pkg::DATA_W-1:0]  rdata_reg, rdata_next;

    // RAM ports
    logic                         pt_we;
    logic [PT_AW-1:0]             pt_addr;
    logic [FRAME_W-1:0]           pt_wdata, pt_rdata;
    logic                         ph_we;
    logic [PA_W-1:0]              ph_addr;
    logic [dpfa_pkg::DATA_W-1:0]  ph_wdata, ph_rdata;

    dpfa_ram #(.WIDTH(FRAME_W), .DEPTH(1 << PT_AW)) u_page_table (
        .clk   (clk),
        .we    (pt_we),
        .addr  (pt_addr),
        .wdata (pt_wdata),
        .rdata (pt_rdata)
    );

    dpfa_ram #(.WIDTH(dpfa_pkg::DATA_W), .DEPTH(PH_DEPTH)) u_phys_mem (
        .clk   (clk),
        .we    (ph_we),
        .addr  (ph_addr),
        .wdata (ph_wdata),
        .rdata (ph_rdata)
    );

    // Decode of the incoming command word
    logic                        pid_ok;
    logic [SLOT_W-1:0]           pid_in;
    logic [VPN_W-1:0]            vpn_in;
    logic [PT_AW-1:0]            idx_in;
    logic [NP_W-1:0]             np_in;
    logic [NP_W-1:0]             np_exit;
    logic                        free_found;
    logic [SLOT_W-1:0]           free_slot;
    logic [SUM_W-1:0]            res_sum;
    logic [PT_AW-1:0]            ex_idx;
    logic [dpfa_pkg::SIZE_W-1:0] cur_size;

    assign pid_ok   = 32'(proc_id) < NUM_PROCS;
    assign pid_in   = SLOT_W'(proc_id);
    assign vpn_in   = VPN_W'(vaddr >> OFF_W);
    assign idx_in   = PT_AW'(32'(pid_in) * VPAGES) + PT_AW'(vpn_in);
    assign np_in    = NP_W'((32'(size_bytes) + PAGE_BYTES - 1) >> OFF_W);
    assign cur_size = size_reg[pid_in];
    assign np_exit  = NP_W'((32'(size_reg[pid_reg]) + PAGE_BYTES - 1) >> OFF_W);
    assign res_sum  = SUM_W'(reserved_reg) + SUM_W'(np_in);
    assign ex_idx   = PT_AW'(32'(pid_reg) * VPAGES) + PT_AW'(vcnt_reg);

    // Lowest idle slot (priority encode)
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_PROCS - 1; s >= 0; s--)
        begin
            if (!running_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        running_next  = running_reg;
        size_next     = size_reg;
        present_next  = present_reg;
        used_next     = used_reg;
        reserved_next = reserved_reg;
        op_next       = op_reg;
        pid_next      = pid_reg;
        off_next      = off_reg;
        wdata_next    = wdata_reg;
        idx_next      = idx_reg;
        frame_next    = frame_reg;
        fcnt_next     = fcnt_reg;
        zcnt_next     = zcnt_reg;
        vcnt_next     = vcnt_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        newpid_next   = newpid_reg;
        rdata_next    = rdata_reg;
        pt_we         = 1'b0;
        pt_addr       = idx_reg;
        pt_wdata      = frame_reg;
        ph_we         = 1'b0;
        ph_addr       = {frame_reg, off_reg};
        ph_wdata      = wdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    pid_next    = pid_in;
                    off_next    = vaddr[OFF_W-1:0];
                    wdata_next  = wdata;
                    idx_next    = idx_in;
                    status_next = dpfa_pkg::ST_OK;
                    newpid_next = '0;
                    rdata_next  = '0;
                    if (op == dpfa_pkg::OP_CREATE)
                    begin
                        done_next = 1'b1;
                        if (size_bytes == '0 || 32'(size_bytes) > VIRT_BYTES)
                        begin
                            status_next = dpfa_pkg::ST_BAD_SIZE;
                        end
                        else if (!free_found)
                        begin
                            status_next = dpfa_pkg::ST_NO_SLOT;
                        end
                        else if (32'(res_sum) > FRAMES)
                        begin
                            status_next = dpfa_pkg::ST_NO_RESERVE;
                        end
                        else
                        begin
                            for (int v = 0; v < VPAGES; v++)
                            begin
                                present_next[PT_AW'(32'(free_slot) * VPAGES + v)] = 1'b0;
                            end
                            running_next[free_slot] = 1'b1;
                            size_next[free_slot]    = size_bytes;
                            reserved_next           = RES_W'(res_sum);
                            newpid_next             = dpfa_pkg::PID_W'(free_slot);
                        end
                    end
                    else if (!pid_ok || !running_reg[pid_in])
                    begin
                        done_next   = 1'b1;
                        status_next = dpfa_pkg::ST_IDLE;
                    end
                    else if (op == dpfa_pkg::OP_EXIT)
                    begin
                        vcnt_next  = '0;
                        state_next = S_EX_RD;
                    end
                    else if (dpfa_pkg::SIZE_W'(vaddr) >= cur_size)
                    begin
                        done_next   = 1'b1;
                        status_next = dpfa_pkg::ST_OOB;
                    end
                    else if (present_reg[idx_in])
                    begin
                        pt_addr    = idx_in;
                        state_next = S_PT_WAIT;
                    end
                    else
                    begin
                        fcnt_next  = '0;
                        state_next = S_FSCAN;
                    end
                end
            end

            S_PT_WAIT:
            begin
                frame_next = pt_rdata;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                if (op_reg == dpfa_pkg::OP_WRITE)
                begin
                    ph_we      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_WAIT;
                end
            end

            S_RD_WAIT:
            begin
                rdata_next = ph_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // First-fit scan, one frame per cycle
            S_FSCAN:
            begin
                if (32'(fcnt_reg) >= FRAMES)
                begin
                    status_next = dpfa_pkg::ST_NO_FRAME;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!used_reg[fcnt_reg[FRAME_W-1:0]])
                begin
                    used_next[fcnt_reg[FRAME_W-1:0]] = 1'b1;
                    present_next[idx_reg]            = 1'b1;
                    pt_we      = 1'b1;
                    pt_wdata   = fcnt_reg[FRAME_W-1:0];
                    frame_next = fcnt_reg[FRAME_W-1:0];
                    zcnt_next  = '0;
                    state_next = S_ZERO;
                end
                else
                begin
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end

            S_ZERO:
            begin
                ph_we     = 1'b1;
                ph_addr   = {frame_reg, zcnt_reg};
                ph_wdata  = '0;
                zcnt_next = zcnt_reg + 1'b1;
                if (zcnt_reg == OFF_W'(PAGE_BYTES - 1))
                begin
                    state_next = S_ACC;
                end
            end

            S_EX_RD:
            begin
                pt_addr    = ex_idx;
                idx_next   = ex_idx;
                state_next = S_EX_USE;
            end

            S_EX_USE:
            begin
                if (present_reg[idx_reg])
                begin
                    used_next[pt_rdata]   = 1'b0;
                    present_next[idx_reg] = 1'b0;
                end
                vcnt_next = vcnt_reg + 1'b1;
                if (vcnt_reg == VPN_W'(VPAGES - 1))
                begin
                    reserved_next = (32'(reserved_reg) >= 32'(np_exit))
                                  ? RES_W'(32'(reserved_reg) - 32'(np_exit)) : '0;
                    size_next[pid_reg]    = '0;
                    running_next[pid_reg] = 1'b0;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_EX_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            running_reg  <= '0;
            size_reg     <= '{default: '0};
            present_reg  <= '0;
            used_reg     <= '0;
            reserved_reg <= '0;
            op_reg       <= '0;
            pid_reg      <= '0;
            off_reg      <= '0;
            wdata_reg    <= '0;
            idx_reg      <= '0;
            frame_reg    <= '0;
            fcnt_reg     <= '0;
            zcnt_reg     <= '0;
            vcnt_reg     <= '0;
            done_reg     <= 1'b0;
            status_reg   <= '0;
            newpid_reg   <= '0;
            rdata_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            size_reg     <= size_next;
            present_reg  <= present_next;
            used_reg     <= used_next;
            reserved_reg <= reserved_next;
            op_reg       <= op_next;
            pid_reg      <= pid_next;
            off_reg      <= off_next;
            wdata_reg    <= wdata_next;
            idx_reg      <= idx_next;
            frame_reg    <= frame_next;
            fcnt_reg     <= fcnt_next;
            zcnt_reg     <= zcnt_next;
            vcnt_reg     <= vcnt_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            newpid_reg   <= newpid_next;
            rdata_reg    <= rdata_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign new_proc_id = newpid_reg;
    assign rdata       = rdata_reg;

`ifndef SYNTHESIS
    // Every result lands as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while sequencer busy");

    // An accepted command either answers at once or starts a walk
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command dropped");

    // Failed commands carry zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != dpfa_pkg::ST_OK) |-> (rdata == '0 && new_proc_id == '0))
        else $error("nonzero payload on failed command");

    // Reservation never exceeds the frame pool
    a_reserve_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(reserved_reg) <= FRAMES)
        else $error("reserved pages exceed frame count");
`endif

endmodule

>>> rtl/dpfa_ram.sv
// dpfa_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module dpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> dv/dpfa_scoreboard.sv
// dpfa_scoreboard: page-table predictor and expected-result queue for the frame allocator.
// Depends on dpfa_pkg for op and status codes and field widths.
import dpfa_pkg::*;

typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  new_proc_id;
    logic [DATA_W-1:0] rdata;
} dpfa_result_t;

class dpfa_scoreboard;
    localparam int NPROC  = NUM_PROCS_DEF;
    localparam int PGB    = PAGE_BYTES_DEF;
    localparam int VPG    = (VIRT_BYTES_DEF + PGB - 1) / PGB;
    localparam int NFRAME = PHYS_BYTES_DEF / PGB;

    bit          running [NPROC];
    int unsigned proc_size [NPROC];
    bit          present [NPROC*VPG];
    int unsigned frame_of [NPROC*VPG];
    bit          frame_busy [NFRAME];
    int unsigned reserved;
    logic [7:0]  mem [PHYS_BYTES_DEF];
    dpfa_result_t pending[$];
    int errors;

    function int unsigned pages_for(int unsigned n);
        return (n + PGB - 1) / PGB;
    endfunction

    function int free_frame();
        for (int f = 0; f < NFRAME; f++)
            if (!frame_busy[f]) return f;
        return -1;
    endfunction

    function int free_slot();
        for (int s = 0; s < NPROC; s++)
            if (!running[s]) return s;
        return -1;
    endfunction

    // Predict the result of one accepted command word and queue it.
    function void note_command(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [VADDR_W-1:0] va, logic [SIZE_W-1:0] sz,
                               logic [DATA_W-1:0] wd);
        dpfa_result_t r;
        int s;
        int f;
        int idx;
        r = '0;
        r.status = ST_OK;
        if (op == OP_CREATE) begin
            s = free_slot();
            if (sz == 0 || sz > VIRT_BYTES_DEF) r.status = ST_BAD_SIZE;
            else if (s < 0) r.status = ST_NO_SLOT;
            else if (reserved + pages_for(sz) > NFRAME) r.status = ST_NO_RESERVE;
            else begin
                for (int v = 0; v < VPG; v++) present[s*VPG+v] = 0;
                running[s] = 1;
                proc_size[s] = sz;
                reserved += pages_for(sz);
                r.new_proc_id = s;
            end
        end else if (pid >= NPROC || !running[pid]) begin
            r.status = ST_IDLE;
        end else if (op == OP_EXIT) begin
            for (int v = 0; v < VPG; v++) begin
                idx = pid*VPG + v;
                if (present[idx]) begin
                    frame_busy[frame_of[idx]] = 0;
                    present[idx] = 0;
                end
            end
            reserved -= pages_for(proc_size[pid]);
            proc_size[pid] = 0;
            running[pid] = 0;
        end else if (va >= proc_size[pid]) begin
            r.status = ST_OOB;
        end else begin
            idx = pid*VPG + va / PGB;
            if (!present[idx]) begin
                f = free_frame();
                if (f >= 0) begin
                    frame_busy[f] = 1;
                    present[idx] = 1;
                    frame_of[idx] = f;
                    for (int b = 0; b < PGB; b++) mem[f*PGB+b] = 8'h00;
                end
            end
            if (!present[idx]) r.status = ST_NO_FRAME;
            else if (op == OP_READ) r.rdata = mem[frame_of[idx]*PGB + va % PGB];
            else mem[frame_of[idx]*PGB + va % PGB] = wd;
        end
        pending.push_back(r);
    endfunction

    function void check_result(dpfa_result_t got);
        dpfa_result_t want;
        if (pending.size() == 0) begin
            $display("%0t: result word with nothing expected: status %0d", $time, got.status);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.new_proc_id !== want.new_proc_id) begin
            $display("%0t: new_proc_id expected %0d actual %0d", $time,
                     want.new_proc_id, got.new_proc_id);
            errors++;
        end
        if (got.rdata !== want.rdata) begin
            $display("%0t: rdata expected %0h actual %0h", $time, want.rdata, got.rdata);
            errors++;
        end
    endfunction
endclass

>>> dv/testbench.sv
// testbench: self-checking bench for demand_paging_frame_allocator_top.
// Depends on dpfa_pkg, dpfa_scoreboard.sv and the RTL; drives commands, checks results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [dpfa_pkg::OP_W-1:0]    op;
    logic [dpfa_pkg::PID_W-1:0]   proc_id;
    logic [dpfa_pkg::VADDR_W-1:0] vaddr;
    logic [dpfa_pkg::SIZE_W-1:0]  size_bytes;
    logic [dpfa_pkg::DATA_W-1:0]  wdata;
    logic                         done;
    logic [dpfa_pkg::STAT_W-1:0]  status;
    logic [dpfa_pkg::PID_W-1:0]   new_proc_id;
    logic [dpfa_pkg::DATA_W-1:0]  rdata;

    dpfa_scoreboard paging_sb;
    int idle_pct;     // chance in percent that the sender inserts a gap

    demand_paging_frame_allocator_top dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Results cannot be stalled: every done pulse is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            paging_sb.check_result('{status, new_proc_id, rdata});
    end

    // Issue one command word; holds start until the block accepts it.
    // Called and returning at a falling edge; start stays high until the next call.
    task automatic send_word(logic [dpfa_pkg::OP_W-1:0] o, logic [dpfa_pkg::PID_W-1:0] p,
                             logic [dpfa_pkg::VADDR_W-1:0] va,
                             logic [dpfa_pkg::SIZE_W-1:0] sz,
                             logic [dpfa_pkg::DATA_W-1:0] wd);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        op <= o;
        proc_id <= p;
        vaddr <= va;
        size_bytes <= sz;
        wdata <= wd;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        paging_sb.note_command(o, p, va, sz, wd);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (paging_sb.pending.size() != 0)
            @(negedge clk);
    endtask

    // Random byte access aimed mostly at running slots and inside their size.
    task automatic random_access();
        int p;
        int lim;
        p = $urandom_range(7);
        for (int k = 0; k < 8; k++)
            if (!paging_sb.running[p]) p = $urandom_range(7);
        lim = paging_sb.proc_size[p];
        if (lim > 0 && $urandom_range(9) < 8)
            send_word($urandom_range(1, 2) == 1 ? dpfa_pkg::OP_READ : dpfa_pkg::OP_WRITE, p,
                      $urandom_range(lim - 1), $urandom, $urandom);
        else
            send_word($urandom_range(1, 2) == 1 ? dpfa_pkg::OP_READ : dpfa_pkg::OP_WRITE,
                      $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_phase(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_word(dpfa_pkg::OP_CREATE, $urandom, $urandom,
                          $urandom_range(1, 1024), $urandom);
            else if (pick < 10)
                send_word(dpfa_pkg::OP_CREATE, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 14)
                send_word(dpfa_pkg::OP_EXIT, $urandom, $urandom, $urandom, $urandom);
            else
                random_access();
        end
    endtask

    initial
    begin
        paging_sb = new();
        idle_pct = 0;
        rst_n = 0;
        start = 0;
        op = dpfa_pkg::OP_CREATE;
        proc_id = '0;
        vaddr = '0;
        size_bytes = '0;
        wdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: bad sizes, idle slots, bounds, first touch, reservation and slot exhaustion, exit.
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 0, 0);            // size zero
        send_word(dpfa_pkg::OP_CREATE, 7, 1023, 1025, 255);    // just above space size
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 2047, 0);
        send_word(dpfa_pkg::OP_READ, 7, 1023, 0, 0);           // idle slot
        send_word(dpfa_pkg::OP_EXIT, 3, 0, 0, 0);
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 1, 0);            // slot 0, one byte
        send_word(dpfa_pkg::OP_WRITE, 0, 1, 0, 8'hAA);         // out of bounds by one
        send_word(dpfa_pkg::OP_READ, 0, 0, 0, 0);              // first touch reads zero
        send_word(dpfa_pkg::OP_WRITE, 0, 0, 0, 8'hFF);
        send_word(dpfa_pkg::OP_READ, 0, 0, 0, 0);
        for (int i = 1; i < 5; i++)
            send_word(dpfa_pkg::OP_CREATE, 0, 0, 1024, 0);     // last one overflows the pool
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 1, 0);            // one page still fits
        send_word(dpfa_pkg::OP_WRITE, 1, 1023, 0, 8'h55);
        send_word(dpfa_pkg::OP_READ, 1, 1023, 0, 0);
        send_word(dpfa_pkg::OP_EXIT, 0, 0, 0, 0);
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 64, 0);
        for (int i = 5; i < 8; i++)
            send_word(dpfa_pkg::OP_CREATE, 0, 0, 1, 0);        // fill all slots
        send_word(dpfa_pkg::OP_CREATE, 0, 0, 1, 0);            // no slot left
        wait_drain();                                // sender holds until all results are in

        idle_pct = 8;
        random_phase(400);
        // Touch every page of each running slot so frames fill up; the reservation keeps first touch from failing.
        for (int p = 0; p < 8; p++)
            for (int v = 0; v < 1024; v += 64)
                if (paging_sb.running[p] && v < paging_sb.proc_size[p])
                    send_word(dpfa_pkg::OP_WRITE, p, v, 0, $urandom);
        idle_pct = 88;
        random_phase(300);
        idle_pct = 0;
        random_phase(400);

        wait_drain();
        repeat (200) @(posedge clk);
        if (paging_sb.errors == 0 && paging_sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
